/* sv/dsa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_pkg
// Types and constants shared by the descriptor slot allocator modules.
// ----------------------------------------------------------------------------
package dsa_pkg;

    localparam int TABLE_COUNT = 4;
    localparam int KIND_W      = 2;
    localparam int IDX_W       = 10;
    localparam int CAP_W       = 11;
    localparam int SLOT_W      = 11;
    localparam int STRIDE_W    = 9;
    localparam int OFFSET_W    = 19;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [STRIDE_W-1:0] MAX_STRIDE    = 9'd256;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET  = 9'd32;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_LOOKUP  = 2'd2;
    localparam logic [1:0] OP_REBUILD = 2'd3;

    localparam logic [KIND_W-1:0] KIND_TEXTURE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUFFER  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TARGET  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_DEPTH   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_DROPPED = 2'd3;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_PUSH   = 2'd1;
    localparam logic [1:0] ACT_POP    = 2'd2;
    localparam logic [1:0] ACT_DIRECT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_TEX_CAP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUF_CAP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RT_CAP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DS_CAP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHADER_SZ  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_SZ  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SZ   = 3'd6;

    typedef logic [CAP_W-1:0]    t_cap;
    typedef logic [STRIDE_W-1:0] t_stride;

    typedef struct packed {
        logic [1:0]        operation;
        logic [KIND_W-1:0] table_kind;
        logic [IDX_W-1:0]  slot_index;
        logic              id_valid;
    } t_req;

    typedef struct packed {
        logic [1:0]          status;
        logic [IDX_W-1:0]    granted_index;
        logic [SLOT_W-1:0]   heap_slot;
        logic [OFFSET_W-1:0] byte_offset;
        logic                shader_visible;
    } t_res;

    // value: stack address, fresh index or looked-up index; data: index to push
    typedef struct packed {
        logic [1:0]        act;
        logic [KIND_W-1:0] kind;
        logic [1:0]        status;
        logic [CAP_W-1:0]  value;
        logic [IDX_W-1:0]  data;
    } t_cmd;

endpackage
`default_nettype wire

/* sv/descriptor_slot_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// descriptor_slot_allocator
// Four LIFO slot tables with allocate, free, lookup and rebuild.
// ----------------------------------------------------------------------------
// The front part takes one item per cycle while its two-entry command queue
// has room; it keeps the per-table counters, so allocations, frees and
// rebuilds resolve there at once. The back part handles one command per cycle
// while the result register drains: a free-list stack read or write, the heap
// slot add, then the stride multiply. A result passes the command queue and
// the stage-one, stage-two and result registers; the sustained rate is one
// item per cycle unless results stall. Freed-index stacks need no clearing
// after reset: only entries below each list's count are ever read.
// Capacities above MAX_SLOTS and strides above 256 are clipped when written.
module descriptor_slot_allocator
    import dsa_pkg::*;
#(
    parameter int MAX_SLOTS = 1024
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_req_valid,
    output logic                  o_req_ready,
    input  t_req                  i_req,
    output logic                  o_res_valid,
    input  wire                   i_res_ready,
    output t_res                  o_res,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data
);

    t_cap [TABLE_COUNT-1:0] r_caps;
    t_stride                r_shader_stride;
    t_stride                r_target_stride;
    t_stride                r_depth_stride;
    t_cap                   n_cap;
    t_stride                n_stride;
    t_stride                cfg_stride_raw;

    logic q_push;
    t_cmd q_cmd;
    logic q_pop;
    logic q_empty;
    logic q_full;
    t_cmd q_head;

    assign n_cap          = (32'(i_cfg_data) > MAX_SLOTS) ? CAP_W'(MAX_SLOTS) : i_cfg_data;
    assign cfg_stride_raw = i_cfg_data[STRIDE_W-1:0];
    assign n_stride       = (cfg_stride_raw > MAX_STRIDE) ? MAX_STRIDE : cfg_stride_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caps          <= '0;
            r_shader_stride <= STRIDE_RESET;
            r_target_stride <= STRIDE_RESET;
            r_depth_stride  <= STRIDE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TEX_CAP:   r_caps[KIND_TEXTURE] <= n_cap;
                REG_BUF_CAP:   r_caps[KIND_BUFFER]  <= n_cap;
                REG_RT_CAP:    r_caps[KIND_TARGET]  <= n_cap;
                REG_DS_CAP:    r_caps[KIND_DEPTH]   <= n_cap;
                REG_SHADER_SZ: r_shader_stride      <= n_stride;
                REG_TARGET_SZ: r_target_stride      <= n_stride;
                REG_DEPTH_SZ:  r_depth_stride       <= n_stride;
                default:       r_shader_stride      <= r_shader_stride;
            endcase
        end
    end

    dsa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .i_caps      (r_caps),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_cmd)
    );

    dsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_head  (q_head)
    );

    dsa_back #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_head        (q_head),
        .o_q_pop         (q_pop),
        .i_tex_cap       (r_caps[KIND_TEXTURE]),
        .i_shader_stride (r_shader_stride),
        .i_target_stride (r_target_stride),
        .i_depth_stride  (r_depth_stride),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_res           (o_res)
    );

endmodule
`default_nettype wire

/* sv/dsa_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_front
// Accepts items, keeps per-table list counters and emits back-end commands.
// ----------------------------------------------------------------------------
module dsa_front
    import dsa_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_req_valid,
    output logic                    o_req_ready,
    input  t_req                    i_req,
    input  t_cap [TABLE_COUNT-1:0]  i_caps,
    input  wire                     i_q_full,
    output logic                    o_q_push,
    output t_cmd                    o_q_cmd
);

    logic [CAP_W-1:0] r_freed_count [TABLE_COUNT];
    logic [CAP_W-1:0] r_next_fresh  [TABLE_COUNT];
    logic [CAP_W-1:0] n_fc;
    logic [CAP_W-1:0] n_nf;
    logic [CAP_W-1:0] cap;
    logic [CAP_W-1:0] fc;
    logic [CAP_W-1:0] nf;
    logic [CAP_W-1:0] fresh;
    logic [CAP_W-1:0] idx_ext;
    logic             accept;

    assign o_req_ready = !i_q_full;
    assign accept      = i_req_valid && o_req_ready;
    assign o_q_push    = accept;

    assign cap     = i_caps[i_req.table_kind];
    assign fc      = r_freed_count[i_req.table_kind];
    assign nf      = r_next_fresh[i_req.table_kind];
    assign fresh   = (nf < cap) ? nf : cap;
    assign idx_ext = CAP_W'(i_req.slot_index);

    always_comb begin
        o_q_cmd.act    = ACT_NONE;
        o_q_cmd.kind   = i_req.table_kind;
        o_q_cmd.status = ST_OK;
        o_q_cmd.value  = '0;
        o_q_cmd.data   = i_req.slot_index;
        n_fc           = fc;
        n_nf           = nf;
        case (i_req.operation)
            OP_ALLOC: begin
                if (fc != '0) begin
                    o_q_cmd.act   = ACT_POP;
                    o_q_cmd.value = fc - 1'b1;
                    n_fc          = fc - 1'b1;
                end else if (nf < cap) begin
                    o_q_cmd.act   = ACT_DIRECT;
                    o_q_cmd.value = nf;
                    n_nf          = nf + 1'b1;
                end else begin
                    o_q_cmd.status = ST_EMPTY;
                end
            end
            OP_FREE: begin
                o_q_cmd.value = idx_ext;
                if (!i_req.id_valid) begin
                    o_q_cmd.status = ST_INVALID;
                end else if (idx_ext >= cap || fc >= fresh) begin
                    o_q_cmd.status = ST_DROPPED;
                end else begin
                    o_q_cmd.act   = ACT_PUSH;
                    o_q_cmd.value = fc;
                    n_fc          = fc + 1'b1;
                end
            end
            OP_LOOKUP: begin
                o_q_cmd.act   = ACT_DIRECT;
                o_q_cmd.value = idx_ext;
                if (idx_ext >= cap) begin
                    o_q_cmd.status = ST_INVALID;
                end
            end
            default: begin
                o_q_cmd.act = ACT_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < TABLE_COUNT; t++) begin
                r_freed_count[t] <= '0;
                r_next_fresh[t]  <= '0;
            end
        end else if (accept) begin
            if (i_req.operation == OP_REBUILD) begin
                for (int t = 0; t < TABLE_COUNT; t++) begin
                    r_freed_count[t] <= '0;
                    r_next_fresh[t]  <= '0;
                end
            end else begin
                r_freed_count[i_req.table_kind] <= n_fc;
                r_next_fresh[i_req.table_kind]  <= n_nf;
            end
        end
    end

endmodule
`default_nettype wire

/* sv/dsa_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_queue
// Short command FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module dsa_queue
    import dsa_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_cmd  i_cmd,
    input  wire   i_pop,
    output logic  o_empty,
    output logic  o_full,
    output t_cmd  o_head
);

    t_cmd              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head  = r_slots[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* sv/dsa_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_back
// Executes commands: free-list stack access, heap slot and byte offset.
// ----------------------------------------------------------------------------
module dsa_back
    import dsa_pkg::*;
#(
    parameter int MAX_SLOTS = 1024
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_q_empty,
    input  t_cmd     i_q_head,
    output logic     o_q_pop,
    input  t_cap     i_tex_cap,
    input  t_stride  i_shader_stride,
    input  t_stride  i_target_stride,
    input  t_stride  i_depth_stride,
    output logic     o_res_valid,
    input  wire      i_res_ready,
    output t_res     o_res
);

    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic [IDX_W-1:0] r_stack [TABLE_COUNT][MAX_SLOTS];
    logic [IDX_W-1:0] r_rd_data;

    logic             r_s1_valid;
    t_cmd             r_s1_cmd;

    logic              r_s2_valid;
    logic [1:0]        r_s2_status;
    logic [IDX_W-1:0]  r_s2_granted;
    logic              r_s2_place;
    logic [KIND_W-1:0] r_s2_kind;
    logic [SLOT_W-1:0] r_s2_slot;
    t_stride           r_s2_stride;

    logic              r_out_valid;
    t_res              r_out;

    logic                     advance;
    logic [AW-1:0]            q_addr;
    logic [SLOT_W-1:0]        got;
    logic [SLOT_W-1:0]        base;
    logic [SLOT_W:0]          slot_sum;
    t_stride                  stride;
    logic [IDX_W-1:0]         granted;
    logic                     place;
    logic [STRIDE_W+SLOT_W-1:0] product;

    assign advance     = !r_out_valid || i_res_ready;
    assign o_q_pop     = advance && !i_q_empty;
    assign q_addr      = AW'(i_q_head.value);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            if (i_q_head.act == ACT_PUSH) begin
                r_stack[i_q_head.kind][q_addr] <= i_q_head.data;
            end
            if (i_q_head.act == ACT_POP) begin
                r_rd_data <= r_stack[i_q_head.kind][q_addr];
            end
        end
    end

    always_comb begin
        got     = r_s1_cmd.value;
        granted = r_s1_cmd.value[IDX_W-1:0];
        place   = 1'b0;
        case (r_s1_cmd.act)
            ACT_POP: begin
                got     = SLOT_W'(r_rd_data);
                granted = r_rd_data;
                place   = 1'b1;
            end
            ACT_DIRECT: begin
                place = 1'b1;
            end
            ACT_PUSH: begin
                granted = r_s1_cmd.data;
            end
            default: begin
                place = 1'b0;
            end
        endcase
        base     = (r_s1_cmd.kind == KIND_BUFFER) ? i_tex_cap : '0;
        slot_sum = base + got;
        case (r_s1_cmd.kind)
            KIND_TARGET: stride = i_target_stride;
            KIND_DEPTH:  stride = i_depth_stride;
            default:     stride = i_shader_stride;
        endcase
    end

    assign product = r_s2_stride * r_s2_slot;

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (o_q_pop) begin
                r_s1_cmd <= i_q_head;
            end
            r_s2_status  <= r_s1_cmd.status;
            r_s2_granted <= granted;
            r_s2_place   <= place;
            r_s2_kind    <= r_s1_cmd.kind;
            r_s2_slot    <= slot_sum[SLOT_W-1:0];
            r_s2_stride  <= stride;

            r_out.status         <= r_s2_status;
            r_out.granted_index  <= r_s2_granted;
            r_out.heap_slot      <= r_s2_place ? r_s2_slot : '0;
            r_out.byte_offset    <= r_s2_place ? product[OFFSET_W-1:0] : '0;
            r_out.shader_visible <= !r_s2_kind[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= o_q_pop;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

endmodule
`default_nettype wire

/* sv/dsa_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsa_checker
// Port-level checks for the descriptor slot allocator.
// ----------------------------------------------------------------------------
module dsa_checker
    import dsa_pkg::*;
(
    input wire   i_clk,
    input wire   i_rst_n,
    input wire   o_res_valid,
    input wire   i_res_ready,
    input t_res  o_res
);

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !i_res_ready |=> o_res_valid && $stable(o_res))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid right after reset");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.status == ST_EMPTY |->
            o_res.granted_index == '0 && o_res.heap_slot == '0 &&
            o_res.byte_offset == '0)
        else $error("empty allocate carries a slot");

    a_dropped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.status == ST_DROPPED |->
            o_res.heap_slot == '0 && o_res.byte_offset == '0)
        else $error("dropped free carries a slot");

endmodule

bind descriptor_slot_allocator dsa_checker u_dsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_res_valid (o_res_valid),
    .i_res_ready (i_res_ready),
    .o_res       (o_res)
);
`default_nettype wire

/* test/descriptor_slot_allocator_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descriptor_slot_allocator_test
// Self-checking bench for the four-table descriptor slot allocator.
// ----------------------------------------------------------------------------
// A directed table covers the reset state, clipped capacities and strides,
// LIFO reuse, full lists, out-of-range ids and rebuild. Random phases follow,
// each with fresh register values and one of four mixes of sender gaps and
// receiver stalls. Each result is checked against the directed table's value
// or, where none is given, a behavioral model of the free lists in the bench.
module descriptor_slot_allocator_test;
    import dsa_pkg::*;

    localparam int MAX_SLOTS      = 1024;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        t_req                  req;
        logic                  typed;
        t_res                  want;
    } t_row;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    t_req                  req = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    t_res                  res;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // model state
    logic [IDX_W-1:0] fl_stack [TABLE_COUNT][MAX_SLOTS];
    int unsigned      fl_depth [TABLE_COUNT];
    int unsigned      fresh_next [TABLE_COUNT];
    t_cap             cap_reg [TABLE_COUNT];
    t_stride          shader_stride;
    t_stride          target_stride;
    t_stride          depth_stride;

    t_res        expected_grants [$];
    t_row        directed_rows [$];
    int unsigned errors = 0;
    int unsigned items_sent = 0;
    int unsigned cycles = 0;
    int unsigned status_seen [4] = '{default: 0};
    int unsigned send_pct = 0;
    int unsigned stall_pct = 0;

    descriptor_slot_allocator #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req_valid(req_valid),
        .o_req_ready(req_ready),
        .i_req      (req),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned clipped_cap(int unsigned k);
        return (cap_reg[k] > MAX_SLOTS) ? MAX_SLOTS : cap_reg[k];
    endfunction

    function automatic t_res resolve_request(t_req r);
        t_res        o;
        int unsigned k, cap, fresh, got, base, slot, stride;
        bit          placed;
        k = r.table_kind;
        cap = clipped_cap(k);
        fresh = (fresh_next[k] < cap) ? fresh_next[k] : cap;
        o = '0;
        o.shader_visible = (r.table_kind == KIND_TEXTURE || r.table_kind == KIND_BUFFER);
        placed = 1'b0;
        got = r.slot_index;
        case (r.operation)
            OP_ALLOC: begin
                if (fl_depth[k] > 0) begin
                    fl_depth[k]--;
                    got = fl_stack[k][fl_depth[k]];
                    placed = 1'b1;
                end else if (fresh_next[k] < cap) begin
                    got = fresh_next[k];
                    fresh_next[k]++;
                    placed = 1'b1;
                end else begin
                    o.status = ST_EMPTY;
                end
            end
            OP_FREE: begin
                o.granted_index = r.slot_index;
                if (!r.id_valid) begin
                    o.status = ST_INVALID;
                end else if (r.slot_index >= cap || fl_depth[k] >= fresh) begin
                    o.status = ST_DROPPED;
                end else begin
                    fl_stack[k][fl_depth[k]] = r.slot_index;
                    fl_depth[k]++;
                end
            end
            OP_LOOKUP: begin
                if (r.slot_index >= cap) o.status = ST_INVALID;
                placed = 1'b1;
            end
            default: begin
                fl_depth = '{default: 0};
                fresh_next = '{default: 0};
            end
        endcase
        if (placed) begin
            base = (r.table_kind == KIND_BUFFER) ? clipped_cap(KIND_TEXTURE) : 0;
            slot = (base + got) & 32'h7FF;
            if (r.table_kind == KIND_TEXTURE || r.table_kind == KIND_BUFFER)
                stride = shader_stride;
            else if (r.table_kind == KIND_TARGET)
                stride = target_stride;
            else
                stride = depth_stride;
            if (stride > MAX_STRIDE) stride = MAX_STRIDE;
            o.granted_index = IDX_W'(got);
            o.heap_slot = SLOT_W'(slot);
            o.byte_offset = OFFSET_W'(stride * slot);
        end
        return o;
    endfunction

    function automatic t_row cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_row row;
        row = '0;
        row.is_cfg = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic t_row req_row(logic [1:0] op, logic [KIND_W-1:0] kind,
                                     logic [IDX_W-1:0] idx, logic valid);
        t_row row;
        row = '0;
        row.req = '{operation: op, table_kind: kind, slot_index: idx, id_valid: valid};
        return row;
    endfunction

    function automatic t_row chk_row(logic [1:0] op, logic [KIND_W-1:0] kind,
                                     logic [IDX_W-1:0] idx, logic valid, logic [1:0] st,
                                     logic [IDX_W-1:0] gi, logic [SLOT_W-1:0] hs,
                                     logic [OFFSET_W-1:0] bo, logic vis);
        t_row row;
        row = req_row(op, kind, idx, valid);
        row.typed = 1'b1;
        row.want = '{status: st, granted_index: gi, heap_slot: hs, byte_offset: bo,
                     shader_visible: vis};
        return row;
    endfunction

    task automatic add_row(input t_row row);
        directed_rows = {directed_rows, row};
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_capacity();
        case ($urandom_range(9))
            0: return '0;
            1: return 11'd1024;
            2: return 11'd2047;
            3: return CFG_DATA_W'($urandom_range(2047));
            default: return CFG_DATA_W'($urandom_range(16, 1));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_stride();
        case ($urandom_range(5))
            0: return '0;
            1: return 11'd1;
            2: return 11'd256;
            3: return 11'd511;
            default: return CFG_DATA_W'($urandom_range(256, 1));
        endcase
    endfunction

    function automatic t_req random_request();
        t_req        r;
        int unsigned roll, cap;
        roll = $urandom_range(99);
        r.operation = (roll < 45) ? OP_ALLOC : (roll < 80) ? OP_FREE :
                      (roll < 97) ? OP_LOOKUP : OP_REBUILD;
        r.table_kind = KIND_W'($urandom_range(3));
        cap = clipped_cap(r.table_kind);
        if (cap > 0 && $urandom_range(3) != 0)
            r.slot_index = IDX_W'($urandom_range(cap - 1));
        else
            r.slot_index = IDX_W'($urandom_range(1023));
        r.id_valid = ($urandom_range(9) != 0);
        return r;
    endfunction

    task automatic issue_request(input t_req r, input bit typed, input t_res typed_res);
        t_res predicted;
        while (send_pct != 0 && $urandom_range(99) < send_pct) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (!req_ready);
        predicted = resolve_request(r);
        expected_grants = {expected_grants, (typed ? typed_res : predicted)};
        items_sent++;
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (expected_grants.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TEX_CAP, REG_BUF_CAP, REG_RT_CAP, REG_DS_CAP: cap_reg[idx] = val;
            REG_SHADER_SZ: shader_stride = val[STRIDE_W-1:0];
            REG_TARGET_SZ: target_stride = val[STRIDE_W-1:0];
            REG_DEPTH_SZ:  depth_stride = val[STRIDE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    always @(posedge clk) begin
        t_res want;
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                if (expected_grants.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item, expected none, actual %h", $time, res);
                end else begin
                    want = expected_grants.pop_front();
                    status_seen[res.status]++;
                    if (res.status !== want.status)
                        report_field("status", want.status, res.status);
                    if (res.granted_index !== want.granted_index)
                        report_field("granted_index", want.granted_index, res.granted_index);
                    if (res.heap_slot !== want.heap_slot)
                        report_field("heap_slot", want.heap_slot, res.heap_slot);
                    if (res.byte_offset !== want.byte_offset)
                        report_field("byte_offset", want.byte_offset, res.byte_offset);
                    if (res.shader_visible !== want.shader_visible)
                        report_field("shader_visible", want.shader_visible, res.shader_visible);
                end
            end
            res_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout with %0d items outstanding", expected_grants.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        cap_reg = '{default: '0};
        shader_stride = STRIDE_RESET;
        target_stride = STRIDE_RESET;
        depth_stride = STRIDE_RESET;
        fl_depth = '{default: 0};
        fresh_next = '{default: 0};

        // reset state: all tables empty, strides at their reset value
        add_row(chk_row(OP_ALLOC, KIND_TEXTURE, 0, 1, ST_EMPTY, 0, 0, 0, 1));
        add_row(chk_row(OP_FREE, KIND_DEPTH, 1023, 0, ST_INVALID, 1023, 0, 0, 0));
        add_row(chk_row(OP_FREE, KIND_BUFFER, 0, 1, ST_DROPPED, 0, 0, 0, 1));
        add_row(chk_row(OP_LOOKUP, KIND_TARGET, 0, 1, ST_INVALID, 0, 0, 0, 0));
        add_row(chk_row(OP_REBUILD, KIND_BUFFER, 0, 1, ST_OK, 0, 0, 0, 1));
        // oversized capacity and stride get clipped
        add_row(cfg_row(REG_TEX_CAP, 4));
        add_row(cfg_row(REG_BUF_CAP, 2047));
        add_row(cfg_row(REG_RT_CAP, 1024));
        add_row(cfg_row(REG_DS_CAP, 1));
        add_row(cfg_row(REG_SHADER_SZ, 511));
        add_row(cfg_row(REG_TARGET_SZ, 256));
        add_row(cfg_row(REG_DEPTH_SZ, 0));
        add_row(chk_row(OP_ALLOC, KIND_TEXTURE, 0, 1, ST_OK, 0, 0, 0, 1));
        add_row(chk_row(OP_ALLOC, KIND_TEXTURE, 0, 1, ST_OK, 1, 1, 256, 1));
        add_row(chk_row(OP_ALLOC, KIND_BUFFER, 0, 1, ST_OK, 0, 4, 1024, 1));
        add_row(chk_row(OP_FREE, KIND_TEXTURE, 1, 1, ST_OK, 1, 0, 0, 1));
        add_row(chk_row(OP_FREE, KIND_TEXTURE, 0, 1, ST_OK, 0, 0, 0, 1));
        // list full, then index past capacity
        add_row(chk_row(OP_FREE, KIND_TEXTURE, 3, 1, ST_DROPPED, 3, 0, 0, 1));
        add_row(chk_row(OP_FREE, KIND_TEXTURE, 1023, 1, ST_DROPPED, 1023, 0, 0, 1));
        // last freed comes back first
        add_row(chk_row(OP_ALLOC, KIND_TEXTURE, 0, 1, ST_OK, 0, 0, 0, 1));
        add_row(chk_row(OP_ALLOC, KIND_TEXTURE, 0, 1, ST_OK, 1, 1, 256, 1));
        add_row(chk_row(OP_LOOKUP, KIND_BUFFER, 1023, 1, ST_OK, 1023, 1027, 262912, 1));
        add_row(chk_row(OP_LOOKUP, KIND_TEXTURE, 1023, 1, ST_INVALID, 1023, 1023, 261888, 1));
        add_row(chk_row(OP_ALLOC, KIND_DEPTH, 0, 1, ST_OK, 0, 0, 0, 0));
        add_row(chk_row(OP_ALLOC, KIND_DEPTH, 0, 1, ST_EMPTY, 0, 0, 0, 0));
        add_row(req_row(OP_ALLOC, KIND_TARGET, 0, 1));
        add_row(req_row(OP_LOOKUP, KIND_TARGET, 10'h2AA, 0));
        add_row(cfg_row(REG_DEPTH_SZ, 1));
        add_row(cfg_row(REG_TEX_CAP, 1024));
        add_row(chk_row(OP_LOOKUP, KIND_BUFFER, 1023, 1, ST_OK, 1023, 2047, 524032, 1));
        add_row(req_row(OP_LOOKUP, KIND_DEPTH, 0, 1));
        add_row(req_row(OP_FREE, KIND_DEPTH, 0, 1));
        add_row(chk_row(OP_REBUILD, KIND_TEXTURE, 0, 1, ST_OK, 0, 0, 0, 1));
        add_row(req_row(OP_ALLOC, KIND_DEPTH, 0, 1));
        add_row(req_row(OP_ALLOC, KIND_TEXTURE, 0, 1));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg) begin
                settle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end else begin
                issue_request(directed_rows[i].req, directed_rows[i].typed,
                              directed_rows[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p % 4)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 58; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 58; end
                default: begin send_pct = 31; stall_pct = 31; end
            endcase
            write_reg(REG_TEX_CAP, random_capacity());
            write_reg(REG_BUF_CAP, random_capacity());
            write_reg(REG_RT_CAP, random_capacity());
            write_reg(REG_DS_CAP, random_capacity());
            write_reg(REG_SHADER_SZ, random_stride());
            write_reg(REG_TARGET_SZ, random_stride());
            write_reg(REG_DEPTH_SZ, random_stride());
            repeat (ITEMS_PER_PHASE) issue_request(random_request(), 1'b0, '0);
        end

        settle();
        repeat (10) @(posedge clk);
        $display("Sent %0d items across %0d register settings and four pressure mixes.",
                 items_sent, PHASES + 2);
        $display("Status mix: ok %0d, empty %0d, invalid id %0d, dropped free %0d.",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_INVALID],
                 status_seen[ST_DROPPED]);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* descriptor_slot_allocator.f */
sv/dsa_pkg.sv
sv/dsa_front.sv
sv/dsa_queue.sv
sv/dsa_back.sv
sv/descriptor_slot_allocator.sv
sv/dsa_checker.sv
test/descriptor_slot_allocator_test.sv
